@@ hdl/gdes_pkg.sv @@
`timescale 1ns / 1ps
package gdes_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MA,
    ST_MB,
    ST_MC,
    ST_MD,
    ST_CHK,
    ST_TA,
    ST_TB,
    ST_TC,
    ST_DIV,
    ST_SEL,
    ST_APP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  localparam int NUM_SPECIES = 6;
  localparam int NUM_REACT   = 12;
  localparam logic [3:0] NO_REACTION = 4'd12;
  localparam logic [3:0] LAST_REACTION = 4'd11;

  localparam int SP_A = 0;
  localparam int SP_B = 1;
  localparam int SP_C = 2;
  localparam int SP_D = 3;
  localparam int SP_E = 4;
  localparam int SP_F = 5;

  localparam logic [2:0] REG_RATES_FIRST  = 3'd0;
  localparam logic [2:0] REG_RATES_MIDDLE = 3'd1;
  localparam logic [2:0] REG_RATES_LAST   = 3'd2;
  localparam logic [2:0] REG_TOTAL_C      = 3'd3;
  localparam logic [2:0] REG_TOTAL_D      = 3'd4;
  localparam logic [2:0] REG_TIME_LIMIT   = 3'd5;

  // bit j is species j (A lowest)
  localparam logic [NUM_REACT-1:0][5:0] EFF_INC = '{
    6'b000000, // 11
    6'b000000, // 10
    6'b000000, // 9
    6'b000000, // 8
    6'b010000, // 7: E+
    6'b000001, // 6: A+
    6'b100000, // 5: F+
    6'b000010, // 4: B+
    6'b100100, // 3: F+ C+
    6'b000000, // 2
    6'b101000, // 1: F+ D+
    6'b000000  // 0
  };

  localparam logic [NUM_REACT-1:0][5:0] EFF_DEC = '{
    6'b010000, // 11: E-
    6'b100000, // 10: F-
    6'b000001, // 9: A-
    6'b000010, // 8: B-
    6'b000000,
    6'b000000,
    6'b000000,
    6'b000000,
    6'b000000,
    6'b100100, // 2: F- C-
    6'b000000,
    6'b101000  // 0: F- D-
  };

endpackage

@@ hdl/gdes_mul.sv @@
`timescale 1ns / 1ps
module gdes_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

@@ hdl/gdes_div.sv @@
`timescale 1ns / 1ps
module gdes_div #(
  parameter int NUM_W = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [63:0]         den,
  output logic [NUM_W-1:0]    quo,
  output gdes_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [63:0]      rem;
  logic [NUM_W-1:0] shf;
  logic [64:0]      trial;
  logic             fits;

  assign trial = {rem, shf[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign stat.busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      shf <= num;
    end else if (cnt != '0) begin
      rem <= fits ? 64'(trial - {1'b0, den}) : trial[63:0];
      shf <= {shf[NUM_W-2:0], fits};
    end
  end

  assign quo = shf;

endmodule

@@ hdl/gillespie_direct_event_step.sv @@
`timescale 1ns / 1ps
// At most one Gillespie direct-method event per simulate transaction on the
// six-species network; a load transaction sets the counts and clears time and
// the finished flag. A simulate item forms twelve propensities in four steps
// each through one shared 32x32 multiplier, then runs a restoring divider for
// the time step that yields one bit per cycle while the multiplier forms the
// selection threshold, then a cumulative-sum search over up to twelve
// reactions and a step to apply the reaction. A load or an already finished
// item goes straight to the result. The input is not ready while an item is in
// work or its result waits.
module gillespie_direct_event_step #(
  parameter int COUNT_BITS     = 16,
  parameter int RATE_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // load_a, load_b, load_c, load_d, load_e, load_f, uniform_sample, exp_sample
  input  logic [159:0] s_tdata,
  // opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // count_a..count_f, sim_time, fired_reaction, finished, 3 zero bits
  output logic [151:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int NUM_W = 24 + RATE_FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  gdes_pkg::state_t state, state_next;

  logic [63:0] rates_first, rates_middle, rates_last;
  logic [15:0] total_c, total_d;
  logic [47:0] time_limit;

  logic [COUNT_BITS-1:0] cnt [gdes_pkg::NUM_SPECIES];
  logic [47:0] elapsed;
  logic        done;
  logic [3:0]  fired;
  logic [3:0]  k;
  logic [31:0] uni;
  logic [31:0] expv;
  logic [63:0] prop [gdes_pkg::NUM_REACT];
  logic [63:0] total;
  logic [63:0] thr;
  logic [63:0] cum;
  logic [31:0] mhi;
  logic [47:0] plo;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start;
  logic [NUM_W-1:0] div_q;
  gdes_pkg::div_stat_t div_stat;

  logic [15:0] rate_k;
  logic [31:0] single_k;
  logic [63:0] mval;
  logic        prod_k;
  logic [80:0] prop_wide;
  logic [63:0] prop_sat;
  logic [64:0] tot_sum;
  logic [64:0] cum_sum;
  logic [63:0] cum_sat;
  logic [48:0] newt;

  gdes_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  gdes_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUM_W'(expv) << (RATE_FRAC_BITS - 8)),
    .den   (total),
    .quo   (div_q),
    .stat  (div_stat)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rates_first  <= '0;
      rates_middle <= '0;
      rates_last   <= '0;
      total_c      <= '0;
      total_d      <= '0;
      time_limit   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gdes_pkg::REG_RATES_FIRST:  rates_first  <= cfg_data;
        gdes_pkg::REG_RATES_MIDDLE: rates_middle <= cfg_data;
        gdes_pkg::REG_RATES_LAST:   rates_last   <= cfg_data;
        gdes_pkg::REG_TOTAL_C:      total_c      <= cfg_data[15:0];
        gdes_pkg::REG_TOTAL_D:      total_d      <= cfg_data[15:0];
        gdes_pkg::REG_TIME_LIMIT:   time_limit   <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (k[3:2])
      2'd0:    rate_k = rates_first[16*k[1:0] +: 16];
      2'd1:    rate_k = rates_middle[16*k[1:0] +: 16];
      default: rate_k = rates_last[16*k[1:0] +: 16];
    endcase
  end

  // multiplier that needs no product of counts
  always_comb begin
    single_k = '0;
    case (k)
      4'd1: single_k = (32'(cnt[gdes_pkg::SP_D]) >= 32'(total_d)) ? '0
                       : 32'(total_d) - 32'(cnt[gdes_pkg::SP_D]);
      4'd3: single_k = (32'(cnt[gdes_pkg::SP_C]) >= 32'(total_c)) ? '0
                       : 32'(total_c) - 32'(cnt[gdes_pkg::SP_C]);
      4'd4:  single_k = 32'(cnt[gdes_pkg::SP_D]);
      4'd5:  single_k = 32'(cnt[gdes_pkg::SP_B]);
      4'd6:  single_k = 32'(cnt[gdes_pkg::SP_C]);
      4'd7:  single_k = 32'(cnt[gdes_pkg::SP_A]);
      4'd8:  single_k = 32'(cnt[gdes_pkg::SP_B]);
      4'd9:  single_k = 32'(cnt[gdes_pkg::SP_A]);
      4'd10: single_k = 32'(cnt[gdes_pkg::SP_F]);
      4'd11: single_k = 32'(cnt[gdes_pkg::SP_E]);
      default: single_k = '0;
    endcase
  end

  assign prod_k    = (k == 4'd0) || (k == 4'd2);
  assign mval      = prod_k ? mul_p : 64'(single_k);
  assign prop_wide = {33'd0, mul_p[47:0]} << 32;
  assign prop_sat  = ((prop_wide + 81'(plo)) >> 64) != '0 ? '1
                     : 64'(prop_wide + 81'(plo));
  assign tot_sum   = 65'(total) + 65'(prop_sat);
  assign cum_sum   = 65'(cum) + 65'(prop[k]);
  assign cum_sat   = cum_sum[64] ? '1 : cum_sum[63:0];
  assign newt      = 49'(elapsed) + 49'(div_q);

  always_comb begin
    state_next = state;
    unique case (state)
      gdes_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (!s_tuser || done || elapsed >= time_limit) state_next = gdes_pkg::ST_OUT;
          else state_next = gdes_pkg::ST_MA;
        end
      end
      gdes_pkg::ST_MA: state_next = gdes_pkg::ST_MB;
      gdes_pkg::ST_MB: state_next = gdes_pkg::ST_MC;
      gdes_pkg::ST_MC: state_next = gdes_pkg::ST_MD;
      gdes_pkg::ST_MD: begin
        state_next = (k == gdes_pkg::LAST_REACTION) ? gdes_pkg::ST_CHK : gdes_pkg::ST_MA;
      end
      gdes_pkg::ST_CHK: begin
        state_next = (total == '0) ? gdes_pkg::ST_OUT : gdes_pkg::ST_TA;
      end
      gdes_pkg::ST_TA: state_next = gdes_pkg::ST_TB;
      gdes_pkg::ST_TB: state_next = gdes_pkg::ST_TC;
      gdes_pkg::ST_TC: state_next = gdes_pkg::ST_DIV;
      gdes_pkg::ST_DIV: begin
        if (!div_stat.busy) begin
          state_next = (newt > 49'(time_limit)) ? gdes_pkg::ST_OUT : gdes_pkg::ST_SEL;
        end
      end
      gdes_pkg::ST_SEL: begin
        if (cum_sat > thr || k == gdes_pkg::LAST_REACTION) state_next = gdes_pkg::ST_APP;
      end
      gdes_pkg::ST_APP: state_next = gdes_pkg::ST_OUT;
      gdes_pkg::ST_OUT: if (m_tready) state_next = gdes_pkg::ST_IDLE;
      default: state_next = gdes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      gdes_pkg::ST_IDLE: s_tready = 1'b1;
      gdes_pkg::ST_MA: begin
        mul_a = 32'(cnt[gdes_pkg::SP_F]);
        mul_b = (k == 4'd0) ? 32'(cnt[gdes_pkg::SP_D]) : 32'(cnt[gdes_pkg::SP_C]);
      end
      gdes_pkg::ST_MB: begin
        mul_a = mval[31:0];
        mul_b = 32'(rate_k);
      end
      gdes_pkg::ST_MC: begin
        mul_a = mhi;
        mul_b = 32'(rate_k);
      end
      gdes_pkg::ST_CHK: div_start = total != '0;
      gdes_pkg::ST_TA: begin
        mul_a = total[63:32];
        mul_b = uni;
      end
      gdes_pkg::ST_TB: begin
        mul_a = total[31:0];
        mul_b = uni;
      end
      gdes_pkg::ST_OUT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < gdes_pkg::NUM_SPECIES; j++) cnt[j] <= '0;
      elapsed <= '0;
      done    <= 1'b0;
      fired   <= gdes_pkg::NO_REACTION;
      k       <= '0;
    end else begin
      unique case (state)
        gdes_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            uni   <= s_tdata[127:96];
            expv  <= s_tdata[159:128];
            fired <= gdes_pkg::NO_REACTION;
            k     <= '0;
            total <= '0;
            if (!s_tuser) begin
              for (int j = 0; j < gdes_pkg::NUM_SPECIES; j++) begin
                cnt[j] <= (32'(s_tdata[16*j +: 16]) > 32'(CMAX)) ? CMAX
                          : COUNT_BITS'(s_tdata[16*j +: 16]);
              end
              elapsed <= '0;
              done    <= 1'b0;
            end else if (done || elapsed >= time_limit) begin
              done <= 1'b1;
            end
          end
        end
        gdes_pkg::ST_MB: mhi <= mval[63:32];
        gdes_pkg::ST_MC: plo <= mul_p[47:0];
        gdes_pkg::ST_MD: begin
          prop[k] <= prop_sat;
          total   <= tot_sum[64] ? '1 : tot_sum[63:0];
          if (k != gdes_pkg::LAST_REACTION) k <= k + 1'b1;
        end
        gdes_pkg::ST_CHK: if (total == '0) done <= 1'b1;
        gdes_pkg::ST_TB: thr <= mul_p;
        gdes_pkg::ST_TC: thr <= thr + 64'(mul_p[63:32]);
        gdes_pkg::ST_DIV: begin
          if (!div_stat.busy) begin
            k   <= '0;
            cum <= '0;
            if (newt > 49'(time_limit)) done <= 1'b1;
            else elapsed <= newt[47:0];
          end
        end
        gdes_pkg::ST_SEL: begin
          cum <= cum_sat;
          if (cum_sat > thr || k == gdes_pkg::LAST_REACTION) fired <= k;
          else k <= k + 1'b1;
        end
        gdes_pkg::ST_APP: begin
          for (int j = 0; j < gdes_pkg::NUM_SPECIES; j++) begin
            if (gdes_pkg::EFF_INC[fired][j] && cnt[j] != CMAX) cnt[j] <= cnt[j] + 1'b1;
            else if (gdes_pkg::EFF_DEC[fired][j] && cnt[j] != '0) cnt[j] <= cnt[j] - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < gdes_pkg::NUM_SPECIES; j++) m_tdata[16*j +: 16] = 16'(cnt[j]);
    m_tdata[143:96]  = elapsed;
    m_tdata[147:144] = fired;
    m_tdata[148]     = done;
  end

endmodule

@@ hdl/gdes_checker.sv @@
`timescale 1ns / 1ps
module gdes_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [159:0] s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic [2:0]   cfg_index,
  input logic [63:0]  cfg_data
);

  // one item in work at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready held after a transaction");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_finished_fires_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[148] |-> m_tdata[147:144] == gdes_pkg::NO_REACTION)
    else $error("finished result reports a fired reaction");

endmodule

bind gillespie_direct_event_step gdes_checker u_gdes_checker (.*);
